// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XBD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define XBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/xbd_pkg.sv =====
// ----------------------------------------------------------------------------
// xbd_pkg
// Constants and operation codes of the XOR bitmap display with scroll.
// ----------------------------------------------------------------------------
package xbd_pkg;

  localparam int DISP_W_DEF = 128;
  localparam int DISP_H_DEF = 64;
  localparam int SIDE_SHIFT = 4;
  localparam int LORES_DIV  = 2;

  // Width of the shared subtractor: covers an 8-bit coordinate and a 256 wide grid.
  localparam int SUB_W = 9;

  localparam logic [2:0] KIND_PLOT  = 3'd0;
  localparam logic [2:0] KIND_CLEAR = 3'd1;
  localparam logic [2:0] KIND_DOWN  = 3'd2;
  localparam logic [2:0] KIND_LEFT  = 3'd3;
  localparam logic [2:0] KIND_RIGHT = 3'd4;
  localparam logic [2:0] KIND_MODE  = 3'd5;
  localparam logic [2:0] KIND_READ  = 3'd6;

endpackage

// ===== rtl/core/xbd_ram.sv =====
// ----------------------------------------------------------------------------
// xbd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module xbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/xor_bitmap_display_with_scroll_unit.sv =====
// ----------------------------------------------------------------------------
// xor_bitmap_display_with_scroll_unit
// One-bit display store with XOR plot, pixel read, clear, scroll and two resolutions.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                      Contents
// in_      in   tvalid tready tdata tuser  one display operation
// out_     out  tvalid tready tdata        collision and pixel of that operation
//
// Each row of the store is one RAM word; a valid bit per row clears it at once.
// Plot and read first wrap x and y by subtraction, then update or sample the pixel.
// Clear, mode, a clipped plot, the unused kind and a trivial scroll down go straight to the output.
// Side scrolls read and rewrite each active row in turn; a scroll down moves or clears each row.
// Reset needs no clearing pass.
// A result waits in the output register; the next item may enter meanwhile.
// ----------------------------------------------------------------------------
module xor_bitmap_display_with_scroll_unit #(
  parameter int DISPLAY_WIDTH  = xbd_pkg::DISP_W_DEF,
  parameter int DISPLAY_HEIGHT = xbd_pkg::DISP_H_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // x[7:0], y[15:8], clip[16], scroll_rows[20:17], hires[21]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // collision[0], pixel[1]
);

  import xbd_pkg::*;

  localparam int W  = DISPLAY_WIDTH;
  localparam int H  = DISPLAY_HEIGHT;
  localparam int CW = $clog2(W);
  localparam int RW = $clog2(H);
  localparam logic [SUB_W-1:0] GW_HI = SUB_W'(W);
  localparam logic [SUB_W-1:0] GW_LO = SUB_W'(W / LORES_DIV);
  localparam logic [SUB_W-1:0] GH_HI = SUB_W'(H);
  localparam logic [SUB_W-1:0] GH_LO = SUB_W'(H / LORES_DIV);
  localparam logic [W-1:0] MASK_LO = {{(W - W / LORES_DIV){1'b0}}, {(W / LORES_DIV){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_PIX, S_SD, S_SDW, S_SS, S_SSW, S_OUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [2:0]       kind_r, kind_nxt;
  logic [7:0]       xw_r, xw_nxt;
  logic [7:0]       yw_r, yw_nxt;
  logic [3:0]       rows_r, rows_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [RW-1:0]    src_r, src_nxt;
  logic [H-1:0]     vld_r, vld_nxt;
  logic             hires_r, hires_nxt;
  logic             coll_r, coll_nxt;
  logic             pix_r, pix_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [7:0]       out_tdata_r, out_tdata_nxt;

  logic [SUB_W-1:0] gw, gh;
  logic [W-1:0]     mask;
  logic [SUB_W-1:0] sub_a, sub_b, sub_diff;
  logic             sub_ge;

  logic             ram_we;
  logic [RW-1:0]    ram_waddr, ram_raddr;
  logic [W-1:0]     ram_wdata, ram_rdata;

  logic [7:0]       in_x, in_y;
  logic             in_clip, in_hires;
  logic [3:0]       in_rows;
  logic [CW-1:0]    col_idx;
  logic [RW-1:0]    row_idx;
  logic [W-1:0]     base_word, hot_word;

  assign in_x     = in_tdata[7:0];
  assign in_y     = in_tdata[15:8];
  assign in_clip  = in_tdata[16];
  assign in_rows  = in_tdata[20:17];
  assign in_hires = in_tdata[21];

  assign gw   = hires_r ? GW_HI : GW_LO;
  assign gh   = hires_r ? GH_HI : GH_LO;
  assign mask = hires_r ? {W{1'b1}} : MASK_LO;

  assign sub_ge   = (sub_a >= sub_b);
  assign sub_diff = sub_a - sub_b;

  assign col_idx   = xw_r[CW-1:0];
  assign row_idx   = yw_r[RW-1:0];
  assign base_word = vld_r[row_idx] ? ram_rdata : '0;
  assign hot_word  = {{(W - 1){1'b0}}, 1'b1} << col_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  xbd_ram #(
    .WIDTH (W),
    .DEPTH (H)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    xw_nxt         = xw_r;
    yw_nxt         = yw_r;
    rows_nxt       = rows_r;
    row_nxt        = row_r;
    src_nxt        = src_r;
    vld_nxt        = vld_r;
    hires_nxt      = hires_r;
    coll_nxt       = coll_r;
    pix_nxt        = pix_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    sub_a          = {1'b0, xw_r};
    sub_b          = gw;
    ram_we         = 1'b0;
    ram_waddr      = row_r;
    ram_wdata      = '0;
    ram_raddr      = row_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          xw_nxt   = in_x;
          yw_nxt   = in_y;
          rows_nxt = in_rows;
          row_nxt  = RW'(gh - SUB_W'(1));
          coll_nxt = 1'b0;
          pix_nxt  = 1'b0;
          state_nxt = S_OUT;
          case (in_tuser)
            KIND_PLOT: begin
              if (!(in_clip && (({1'b0, in_x} >= gw) || ({1'b0, in_y} >= gh)))) begin
                state_nxt = S_WRAP;
              end
            end
            KIND_READ: begin
              state_nxt = S_WRAP;
            end
            KIND_CLEAR: begin
              vld_nxt = '0;
            end
            KIND_MODE: begin
              hires_nxt = in_hires;
              vld_nxt   = '0;
            end
            KIND_DOWN: begin
              if ({5'b0, in_rows} >= gh) begin
                vld_nxt = '0;
              end else if (in_rows != 4'd0) begin
                state_nxt = S_SD;
              end
            end
            KIND_LEFT, KIND_RIGHT: begin
              state_nxt = S_SS;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_WRAP: begin
        if ({1'b0, xw_r} >= gw) begin
          xw_nxt = sub_diff[7:0];
        end else begin
          sub_a = {1'b0, yw_r};
          sub_b = gh;
          if (sub_ge) begin
            yw_nxt = sub_diff[7:0];
          end else begin
            ram_raddr = row_idx;
            state_nxt = S_PIX;
          end
        end
      end
      S_PIX: begin
        if (kind_r == KIND_PLOT) begin
          coll_nxt  = base_word[col_idx];
          ram_we    = 1'b1;
          ram_waddr = row_idx;
          ram_wdata = base_word ^ hot_word;
          vld_nxt[row_idx] = 1'b1;
        end else begin
          pix_nxt = base_word[col_idx];
        end
        state_nxt = S_OUT;
      end
      S_SD: begin
        sub_a = {{(SUB_W - RW){1'b0}}, row_r};
        sub_b = {5'b0, rows_r};
        if (sub_ge) begin
          ram_raddr = sub_diff[RW-1:0];
          src_nxt   = sub_diff[RW-1:0];
          state_nxt = S_SDW;
        end else begin
          vld_nxt[row_r] = 1'b0;
          if (row_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            row_nxt = row_r - RW'(1);
          end
        end
      end
      S_SDW: begin
        ram_we         = 1'b1;
        ram_wdata      = ram_rdata & mask;
        vld_nxt[row_r] = vld_r[src_r];
        if (row_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          row_nxt   = row_r - RW'(1);
          state_nxt = S_SD;
        end
      end
      S_SS: begin
        state_nxt = S_SSW;
      end
      S_SSW: begin
        ram_we = 1'b1;
        if (kind_r == KIND_LEFT) begin
          ram_wdata = (ram_rdata >> SIDE_SHIFT) & mask;
        end else begin
          ram_wdata = (ram_rdata << SIDE_SHIFT) & mask;
        end
        if (row_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          row_nxt   = row_r - RW'(1);
          state_nxt = S_SS;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {6'b0, pix_r, coll_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vld_r        <= '0;
      hires_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vld_r        <= vld_nxt;
      hires_r      <= hires_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    kind_r      <= kind_nxt;
    xw_r        <= xw_nxt;
    yw_r        <= yw_nxt;
    rows_r      <= rows_nxt;
    row_r       <= row_nxt;
    src_r       <= src_nxt;
    coll_r      <= coll_nxt;
    pix_r       <= pix_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// ===== rtl/core/xbd_checker.sv =====
// ----------------------------------------------------------------------------
// xbd_checker
// Port-level checks of the XOR bitmap display with scroll, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xbd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A stalled result stays offered.
  `XBD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // A stalled result keeps its value.
  `XBD_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "result changed while stalled")

  // No item reports both a collision and a pixel value.
  `XBD_ASSERT_SAME(a_one_field, out_tvalid, !(out_tdata[0] && out_tdata[1]), "collision and pixel both set")

  // Every item leaves the idle state, so the input closes after an accept.
  `XBD_ASSERT_NEXT(a_busy, in_tvalid && in_tready, !in_tready, "input still open after accept")

endmodule

bind xor_bitmap_display_with_scroll_unit xbd_checker u_xbd_checker (.*);
